FILE: src/speed_display_pwm_controller_macros.svh
// Assertion helpers shared by the block. Each check is sampled on the rising
// clock edge and is disabled while reset is asserted.
`ifndef SPEED_DISPLAY_PWM_CONTROLLER_MACROS_SVH
`define SPEED_DISPLAY_PWM_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/spd_pkg.sv
package spd_pkg;

	localparam logic [12:0] FULL_SCALE_MV = 13'd5000;
	localparam logic [12:0] PWM_FULL      = 13'd8000;
	localparam logic [17:0] DWELL_FACTOR  = 18'd50;

	localparam logic [6:0] GLYPH_S = 7'h6D;
	localparam logic [6:0] GLYPH_T = 7'h07;
	localparam logic [6:0] GLYPH_O = 7'h3F;
	localparam logic [6:0] GLYPH_P = 7'h73;
	localparam logic [6:0] GLYPH_F = 7'h71;
	localparam logic [6:0] GLYPH_A = 7'h77;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_FAST   = 2'd1,
		MODE_STOP   = 2'd2
	} mode_t;

	typedef struct packed {
		logic [12:0] pwm_compare;
		mode_t       mode;
		logic [6:0]  seg_thousands;
		logic [6:0]  seg_hundreds;
		logic [6:0]  seg_tens;
		logic [6:0]  seg_units;
		logic [7:0]  led_pattern;
		logic [17:0] led_dwell_us;
	} result_t;

	typedef struct packed {
		logic       run;
		logic [2:0] chaser_index;
		logic [7:0] chaser_pattern;
	} ctrl_state_t;

	// Seven-segment code of one decimal digit; the seven also lights f.
	function automatic logic [6:0] digit_glyph(input logic [3:0] digit);
		logic [6:0] code;
		unique case (digit)
			4'd0: code = 7'h3F;
			4'd1: code = 7'h06;
			4'd2: code = 7'h5B;
			4'd3: code = 7'h4F;
			4'd4: code = 7'h66;
			4'd5: code = 7'h6D;
			4'd6: code = 7'h7D;
			4'd7: code = 7'h27;
			4'd8: code = 7'h7F;
			4'd9: code = 7'h6F;
			default: code = 7'h00;
		endcase
		return code;
	endfunction

endpackage

FILE: src/spd_datapath.sv
module spd_datapath (
	input  logic [12:0]          sample_mv,
	input  logic                 button_press,
	input  spd_pkg::ctrl_state_t state_cur,
	output spd_pkg::result_t     result,
	output spd_pkg::ctrl_state_t state_nxt
);

	logic        full;
	logic        run_new;
	logic [12:0] mv;
	logic [31:0] prod_pwm;
	logic [28:0] prod_q10;
	logic [28:0] prod_q100;
	logic [28:0] prod_q1000;
	logic [8:0]  q10;
	logic [5:0]  q100;
	logic [2:0]  q1000;
	logic [12:0] rem_units;
	logic [8:0]  rem_tens;
	logic [5:0]  rem_hundreds;
	logic [2:0]  idx_adv;

	assign full    = (sample_mv >= spd_pkg::FULL_SCALE_MV);
	assign mv      = full ? spd_pkg::FULL_SCALE_MV : sample_mv;
	assign run_new = state_cur.run ^ button_press;

	// Division by five, ten, one hundred and one thousand is done by
	// multiplication with scaled reciprocals, exact over the sample range.
	assign prod_pwm   = {16'd0, mv, 3'b000} * 32'd52429;
	assign prod_q10   = 29'(mv) * 29'd52429;
	assign prod_q100  = 29'(mv) * 29'd5243;
	assign prod_q1000 = 29'(mv) * 29'd8389;

	assign q10   = prod_q10[27:19];
	assign q100  = prod_q100[24:19];
	assign q1000 = prod_q1000[25:23];

	assign rem_units    = mv - ({q10, 3'b000} + {3'b000, q10, 1'b0});
	assign rem_tens     = q10 - ({q100, 3'b000} + {2'b00, q100, 1'b0});
	assign rem_hundreds = q100 - ({q1000, 3'b000} + {2'b00, q1000, 1'b0});

	assign idx_adv = state_cur.chaser_index + 3'd1;

	always_comb begin
		state_nxt     = state_cur;
		state_nxt.run = run_new;
		result.led_dwell_us = '0;
		result.led_pattern  = state_cur.chaser_pattern;
		priority if (full) begin
			result.pwm_compare   = spd_pkg::PWM_FULL;
			result.mode          = spd_pkg::MODE_FAST;
			result.seg_thousands = spd_pkg::GLYPH_F;
			result.seg_hundreds  = spd_pkg::GLYPH_A;
			result.seg_tens      = spd_pkg::GLYPH_S;
			result.seg_units     = spd_pkg::GLYPH_T;
		end else if (run_new) begin
			result.pwm_compare   = prod_pwm[30:18];
			result.mode          = spd_pkg::MODE_NORMAL;
			result.seg_thousands = spd_pkg::digit_glyph({1'b0, q1000});
			result.seg_hundreds  = spd_pkg::digit_glyph(rem_hundreds[3:0]);
			result.seg_tens      = spd_pkg::digit_glyph(rem_tens[3:0]);
			result.seg_units     = spd_pkg::digit_glyph(rem_units[3:0]);
			result.led_dwell_us  = 18'(spd_pkg::FULL_SCALE_MV - mv) * spd_pkg::DWELL_FACTOR;
			state_nxt.chaser_index   = idx_adv;
			state_nxt.chaser_pattern = ~(8'd1 << idx_adv);
			result.led_pattern       = ~(8'd1 << idx_adv);
		end else begin
			result.pwm_compare   = spd_pkg::PWM_FULL;
			result.mode          = spd_pkg::MODE_STOP;
			result.seg_thousands = spd_pkg::GLYPH_S;
			result.seg_hundreds  = spd_pkg::GLYPH_T;
			result.seg_tens      = spd_pkg::GLYPH_O;
			result.seg_units     = spd_pkg::GLYPH_P;
		end
	end

endmodule

FILE: src/speed_display_pwm_controller.sv
// Speed display and PWM controller.
// The input channel (in_valid, in_stall) carries one millivolt sample and a
// brake-button flag per transfer. The output channel (out_valid, out_stall)
// carries one result per input: PWM compare value, mode, four segment codes,
// the LED chaser pattern and the chaser dwell time.
// A sample is captured in an input register, evaluated by a single pass of
// shallow logic, and written into the result register unless that is full
// and stalled. One transfer per cycle is sustained on both channels while
// the receiver does not stall; the run flag and chaser are updated as each
// item leaves the input register, so back-to-back items see the state left
// by the item before them.
// When the receiver stalls, the result register holds its contents, and the
// input register keeps one more item; in_stall rises only when both are
// full and the output is stalled.
// Reset empties both registers, sets the run flag to running, places the
// chaser so that the first normal item lights LED 0, and clears the held
// LED pattern.
`include "speed_display_pwm_controller_macros.svh"

module speed_display_pwm_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [12:0] sample_mv,
	input  logic        button_press,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] pwm_compare,
	output logic [1:0]  mode,
	output logic [6:0]  seg_thousands,
	output logic [6:0]  seg_hundreds,
	output logic [6:0]  seg_tens,
	output logic [6:0]  seg_units,
	output logic [7:0]  led_pattern,
	output logic [17:0] led_dwell_us
);

	logic                 valid_s1;
	logic [12:0]          sample_s1;
	logic                 press_s1;
	logic                 advance;
	logic                 out_valid_q;
	spd_pkg::result_t     result_q;
	spd_pkg::result_t     result_d;
	spd_pkg::ctrl_state_t state_q;
	spd_pkg::ctrl_state_t state_d;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	spd_datapath u_datapath (
		.sample_mv    (sample_s1),
		.button_press (press_s1),
		.state_cur    (state_q),
		.result       (result_d),
		.state_nxt    (state_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample_mv;
			press_s1  <= button_press;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			state_q.run            <= 1'b1;
			state_q.chaser_index   <= 3'd7;
			state_q.chaser_pattern <= 8'd0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			state_q     <= state_d;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign pwm_compare   = result_q.pwm_compare;
	assign mode          = result_q.mode;
	assign seg_thousands = result_q.seg_thousands;
	assign seg_hundreds  = result_q.seg_hundreds;
	assign seg_tens      = result_q.seg_tens;
	assign seg_units     = result_q.seg_units;
	assign led_pattern   = result_q.led_pattern;
	assign led_dwell_us  = result_q.led_dwell_us;

	`SPD_ASSERT_NEXT(a_held_item_kept, valid_s1 && !advance, valid_s1, "held item was dropped")
	`SPD_ASSERT_SAME(a_fast_full_pwm, out_valid && (mode == spd_pkg::MODE_FAST), pwm_compare == spd_pkg::PWM_FULL, "overspeed result without full PWM")
	`SPD_ASSERT_SAME(a_dwell_only_normal, out_valid && (mode != spd_pkg::MODE_NORMAL), led_dwell_us == 18'd0, "dwell reported outside normal mode")
	`SPD_ASSERT_SAME(a_normal_duty_range, out_valid && (mode == spd_pkg::MODE_NORMAL), (pwm_compare < spd_pkg::PWM_FULL) && (led_dwell_us != 18'd0), "normal result out of range")

endmodule

FILE: test/speed_display_pwm_controller_tb.sv
module speed_display_pwm_controller_tb;

	localparam int RANDOM_SAMPLES = 1100;
	localparam int DRAIN_CYCLES   = 8;

	typedef struct packed {
		logic [12:0]      mv;
		logic             press;
		logic             typed;
		spd_pkg::result_t want;
	} drive_row_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	localparam logic [6:0] DIGIT_CODE [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h27, 7'h7F, 7'h6F
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [12:0] sample_mv = '0;
	logic        button_press = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [12:0] pwm_compare;
	logic [1:0]  mode;
	logic [6:0]  seg_thousands;
	logic [6:0]  seg_hundreds;
	logic [6:0]  seg_tens;
	logic [6:0]  seg_units;
	logic [7:0]  led_pattern;
	logic [17:0] led_dwell_us;

	speed_display_pwm_controller dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_mv    (sample_mv),
		.button_press (button_press),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pwm_compare  (pwm_compare),
		.mode         (mode),
		.seg_thousands(seg_thousands),
		.seg_hundreds (seg_hundreds),
		.seg_tens     (seg_tens),
		.seg_units    (seg_units),
		.led_pattern  (led_pattern),
		.led_dwell_us (led_dwell_us)
	);

	// Model of the controller state.
	logic       run_on = 1'b1;
	logic [2:0] chase_pos = 3'd7;
	logic [7:0] chase_leds = 8'h00;

	spd_pkg::result_t pending_displays [$];
	drive_row_t       directed_rows [$];

	int errors = 0;
	int results_seen = 0;
	int burst_left = 0;
	int count_normal = 0;
	int count_fast = 0;
	int count_stop = 0;
	int count_presses = 0;
	stall_style_t stall_style = STALL_NONE;
	int stall_left = 0;
	int stall_tick = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic spd_pkg::result_t next_display(input logic [12:0] mv_in,
			input logic press);
		logic [12:0] mv;
		spd_pkg::result_t r;
		mv = (mv_in > spd_pkg::FULL_SCALE_MV) ? spd_pkg::FULL_SCALE_MV : mv_in;
		r = '0;
		if (press)
			run_on = ~run_on;
		if (mv == spd_pkg::FULL_SCALE_MV) begin
			r.pwm_compare   = spd_pkg::PWM_FULL;
			r.mode          = spd_pkg::MODE_FAST;
			r.seg_thousands = spd_pkg::GLYPH_F;
			r.seg_hundreds  = spd_pkg::GLYPH_A;
			r.seg_tens      = spd_pkg::GLYPH_S;
			r.seg_units     = spd_pkg::GLYPH_T;
		end else if (run_on) begin
			r.pwm_compare   = 13'((32'(mv) * 8) / 5);
			r.mode          = spd_pkg::MODE_NORMAL;
			r.seg_thousands = DIGIT_CODE[(mv / 1000) % 10];
			r.seg_hundreds  = DIGIT_CODE[(mv / 100) % 10];
			r.seg_tens      = DIGIT_CODE[(mv / 10) % 10];
			r.seg_units     = DIGIT_CODE[mv % 10];
			r.led_dwell_us  = spd_pkg::DWELL_FACTOR *
				(18'(spd_pkg::FULL_SCALE_MV) - 18'(mv));
			chase_pos       = chase_pos + 3'd1;
			chase_leds      = ~(8'd1 << chase_pos);
		end else begin
			r.pwm_compare   = spd_pkg::PWM_FULL;
			r.mode          = spd_pkg::MODE_STOP;
			r.seg_thousands = spd_pkg::GLYPH_S;
			r.seg_hundreds  = spd_pkg::GLYPH_T;
			r.seg_tens      = spd_pkg::GLYPH_O;
			r.seg_units     = spd_pkg::GLYPH_P;
		end
		r.led_pattern = chase_leds;
		return r;
	endfunction

	function automatic void add_row(input logic [12:0] mv, input logic press,
			input logic typed, input spd_pkg::result_t want);
		drive_row_t row;
		row.mv    = mv;
		row.press = press;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input logic [12:0] mv, input logic press,
			input logic typed, input spd_pkg::result_t want);
		int gap;
		spd_pkg::result_t predicted;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid     <= 1'b1;
		sample_mv    <= mv;
		button_press <= press;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		predicted = next_display(mv, press);
		pending_displays.push_back(typed ? want : predicted);
		if (press)
			count_presses++;
		case (predicted.mode)
			spd_pkg::MODE_NORMAL: count_normal++;
			spd_pkg::MODE_FAST:   count_fast++;
			default:              count_stop++;
		endcase
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 3));
			stall_left  = $urandom_range(16, 96);
		end
		stall_left--;
		stall_tick++;
		case (stall_style)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= ((stall_tick % 7) < 3);
		endcase
	end

	always @(posedge clk) begin
		spd_pkg::result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (pending_displays.size() == 0) begin
				report_error($sformatf("result %0d arrived with nothing expected", results_seen));
			end else begin
				want = pending_displays.pop_front();
				if (pwm_compare !== want.pwm_compare)
					report_error($sformatf("result %0d pwm_compare %0d, expected %0d",
						results_seen, pwm_compare, want.pwm_compare));
				if (mode !== want.mode)
					report_error($sformatf("result %0d mode %0d, expected %0d",
						results_seen, mode, want.mode));
				if (seg_thousands !== want.seg_thousands)
					report_error($sformatf("result %0d seg_thousands %h, expected %h",
						results_seen, seg_thousands, want.seg_thousands));
				if (seg_hundreds !== want.seg_hundreds)
					report_error($sformatf("result %0d seg_hundreds %h, expected %h",
						results_seen, seg_hundreds, want.seg_hundreds));
				if (seg_tens !== want.seg_tens)
					report_error($sformatf("result %0d seg_tens %h, expected %h",
						results_seen, seg_tens, want.seg_tens));
				if (seg_units !== want.seg_units)
					report_error($sformatf("result %0d seg_units %h, expected %h",
						results_seen, seg_units, want.seg_units));
				if (led_pattern !== want.led_pattern)
					report_error($sformatf("result %0d led_pattern %h, expected %h",
						results_seen, led_pattern, want.led_pattern));
				if (led_dwell_us !== want.led_dwell_us)
					report_error($sformatf("result %0d led_dwell_us %0d, expected %0d",
						results_seen, led_dwell_us, want.led_dwell_us));
			end
		end
	end

	initial begin
		#3000000;
		$display("Timeout with %0d results still expected.", pending_displays.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int pick;
		logic [12:0] mv;
		logic press;

		add_row(13'd0, 1'b0, 1'b1,
			'{13'd0, spd_pkg::MODE_NORMAL, 7'h3F, 7'h3F, 7'h3F, 7'h3F,
				8'hFE, 18'd250000});
		add_row(13'd4999, 1'b0, 1'b1,
			'{13'd7998, spd_pkg::MODE_NORMAL, 7'h66, 7'h6F, 7'h6F, 7'h6F,
				8'hFD, 18'd50});
		add_row(13'd5000, 1'b0, 1'b1,
			'{spd_pkg::PWM_FULL, spd_pkg::MODE_FAST, spd_pkg::GLYPH_F, spd_pkg::GLYPH_A,
				spd_pkg::GLYPH_S, spd_pkg::GLYPH_T, 8'hFD, 18'd0});
		add_row(13'd8191, 1'b0, 1'b1,
			'{spd_pkg::PWM_FULL, spd_pkg::MODE_FAST, spd_pkg::GLYPH_F, spd_pkg::GLYPH_A,
				spd_pkg::GLYPH_S, spd_pkg::GLYPH_T, 8'hFD, 18'd0});
		add_row(13'd1234, 1'b1, 1'b1,
			'{spd_pkg::PWM_FULL, spd_pkg::MODE_STOP, spd_pkg::GLYPH_S, spd_pkg::GLYPH_T,
				spd_pkg::GLYPH_O, spd_pkg::GLYPH_P, 8'hFD, 18'd0});
		add_row(13'd0, 1'b0, 1'b1,
			'{spd_pkg::PWM_FULL, spd_pkg::MODE_STOP, spd_pkg::GLYPH_S, spd_pkg::GLYPH_T,
				spd_pkg::GLYPH_O, spd_pkg::GLYPH_P, 8'hFD, 18'd0});
		add_row(13'd5000, 1'b1, 1'b1,
			'{spd_pkg::PWM_FULL, spd_pkg::MODE_FAST, spd_pkg::GLYPH_F, spd_pkg::GLYPH_A,
				spd_pkg::GLYPH_S, spd_pkg::GLYPH_T, 8'hFD, 18'd0});
		add_row(13'd4096, 1'b0, 1'b0, '0);
		add_row(13'd8190, 1'b1, 1'b0, '0);
		add_row(13'd2500, 1'b0, 1'b0, '0);
		add_row(13'd4095, 1'b1, 1'b0, '0);
		add_row(13'd5001, 1'b0, 1'b0, '0);
		add_row(13'd4567, 1'b0, 1'b0, '0);
		add_row(13'd3890, 1'b0, 1'b0, '0);
		add_row(13'd1234, 1'b0, 1'b0, '0);
		add_row(13'd2109, 1'b0, 1'b0, '0);
		add_row(13'd1, 1'b0, 1'b0, '0);
		add_row(13'd10, 1'b0, 1'b0, '0);
		add_row(13'd100, 1'b0, 1'b0, '0);
		add_row(13'd1000, 1'b0, 1'b0, '0);
		add_row(13'd4998, 1'b0, 1'b0, '0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].mv, directed_rows[i].press,
				directed_rows[i].typed, directed_rows[i].want);

		for (int n = 0; n < RANDOM_SAMPLES; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				mv = 13'($urandom_range(0, 4999));
			else if (pick < 88)
				mv = spd_pkg::FULL_SCALE_MV;
			else if (pick < 94)
				mv = 13'($urandom_range(5001, 8191));
			else
				mv = 13'($urandom_range(0, 8191));
			press = ($urandom_range(0, 9) == 0);
			send_item(mv, press, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_displays.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d directed and %0d random samples.",
			results_seen, directed_rows.size(), RANDOM_SAMPLES);
		$display("Modes seen: %0d normal, %0d overspeed, %0d brake; %0d button presses.",
			count_normal, count_fast, count_stop, count_presses);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
